// ===== rtl/lmo_pkg.sv =====
package lmo_pkg;

  // fixed-point formats
  localparam int unsigned XW        = 32;  // x word, unsigned Q1.31
  localparam int unsigned RW        = 32;  // growth rate word
  localparam int unsigned PW        = 64;  // full product width
  localparam int unsigned FRAC_BITS = 31;  // fraction bits of x
  localparam int unsigned R_FRAC    = 29;  // fraction bits of r
  localparam int unsigned ITER_W    = 16;
  localparam int unsigned TOL_W     = 32;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned NFULL_W   = PW - R_FRAC;

  localparam logic [XW-1:0] ONE_X  = XW'(64'd1 << FRAC_BITS);
  localparam logic [XW-1:0] HALF_X = XW'(64'd1 << (FRAC_BITS - 1));

  // register indexes
  localparam logic REG_ITER = 1'b0;
  localparam logic REG_TOL  = 1'b1;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(1000);
  localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(21475);

  typedef enum logic [1:0] {
    MP_IDLE,
    MP_MUL2,
    MP_SAT
  } map_phase_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRANS,
    S_WAIT,
    S_DECIDE
  } core_state_e;

  typedef struct packed {
    logic load_half;
    logic start;
  } map_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } map_stat_t;

endpackage

// ===== rtl/logistic_map_orbit_finder_core.sv =====
// channel   dir   handshake                  payload
// input     in    in_valid_i / in_ready_o    r_value_i
// result    out   out_valid_o / out_ready_i  r_echo_o, x_value_o, last_o, truncated_o
// config    in    cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// one map step runs on the shared 32x32 multiplier as x*(1-x), then r*p, then saturate
// an item runs iteration_count + L map steps for L result transfers
// in_ready_o is high only while no item is in work; a result may still wait in the
// output register while the next item is taken
// a result waits in its decision state while the output register is full
// async active-low reset clears control state and loads the register defaults
module logistic_map_orbit_finder_core #(
  parameter int unsigned MAX_VALUES = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // config write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [lmo_pkg::CFG_W-1:0]  cfg_data_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [lmo_pkg::RW-1:0]     r_value_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [lmo_pkg::RW-1:0]     r_echo_o,
  output logic [lmo_pkg::XW-1:0]     x_value_o,
  output logic                       last_o,
  output logic                       truncated_o
);
  import lmo_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_VALUES + 1);

  // configuration registers
  logic [ITER_W-1:0] iter_q;
  logic [TOL_W-1:0]  tol_q;

  // sequencer state
  core_state_e       state_q, state_d;
  logic [ITER_W-1:0] k_q;         // transient steps done
  logic [LEN_W-1:0]  len_q;       // values collected so far, pending one included
  logic [RW-1:0]     r_q;
  logic [XW-1:0]     first_q;     // first settled value
  logic [XW-1:0]     pend_q;      // value held until we know whether it is last

  // output register
  logic              out_valid_q;
  logic [RW-1:0]     out_r_q;
  logic [XW-1:0]     out_x_q;
  logic              out_last_q;
  logic              out_trunc_q;

  // map unit
  map_ctrl_t         map_ctrl;
  map_stat_t         map_stat;
  logic [XW-1:0]     map_x;

  // decision terms
  logic              trans_done;
  logic              slot_free;
  logic [XW-1:0]     diff;
  logic              end_hit;
  logic              trunc_hit;
  logic              is_last;
  logic              settle;
  logic              emit;
  logic              k_inc;

  lmo_map_unit u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (map_ctrl),
    .r_i    (r_q),
    .stat_o (map_stat),
    .x_o    (map_x)
  );

  // transient phase finished once the unit is idle and the count is reached
  assign trans_done = (k_q == iter_q) && !map_stat.busy;
  assign slot_free  = !out_valid_q || out_ready_i;

  // new iterate is map_x, compared against the first settled value
  assign diff      = (map_x >= first_q) ? (map_x - first_q) : (first_q - map_x);
  assign end_hit   = (diff < tol_q) || (ITER_W'(len_q) > iter_q);
  assign trunc_hit = (len_q >= LEN_W'(MAX_VALUES));
  assign is_last   = end_hit || trunc_hit;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_TRANS;
      end
      S_TRANS: begin
        if (trans_done) state_d = S_WAIT;
      end
      S_WAIT: begin
        if (map_stat.done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (slot_free) state_d = is_last ? S_IDLE : S_WAIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o         = 1'b0;
    map_ctrl.load_half = 1'b0;
    map_ctrl.start     = 1'b0;
    settle             = 1'b0;
    emit               = 1'b0;
    k_inc              = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o         = 1'b1;
        map_ctrl.load_half = in_valid_i;
      end
      S_TRANS: begin
        // a step is launched either way: another transient step or the first collected one
        map_ctrl.start = !map_stat.busy;
        settle         = trans_done;
        k_inc          = map_stat.done;
      end
      S_DECIDE: begin
        emit           = slot_free;
        map_ctrl.start = slot_free && !is_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= ITER_RESET;
      tol_q       <= TOL_RESET;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      len_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ITER: iter_q <= cfg_data_i[ITER_W-1:0];
          REG_TOL:  tol_q  <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (map_ctrl.load_half) begin
        k_q <= '0;
      end else if (k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (settle) begin
        len_q <= LEN_W'(1);
      end else if (emit && !is_last) begin
        len_q <= len_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (map_ctrl.load_half) begin
      r_q <= r_value_i;
    end
    if (settle) begin
      first_q <= map_x;
      pend_q  <= map_x;
    end else if (emit && !is_last) begin
      pend_q <= map_x;
    end
    if (emit) begin
      out_r_q     <= r_q;
      out_x_q     <= pend_q;
      out_last_q  <= is_last;
      out_trunc_q <= !end_hit && trunc_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign r_echo_o    = out_r_q;
  assign x_value_o   = out_x_q;
  assign last_o      = out_last_q;
  assign truncated_o = out_trunc_q;

endmodule

// ===== rtl/lmo_map_unit.sv =====
module lmo_map_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lmo_pkg::map_ctrl_t      ctrl_i,
  input  logic [lmo_pkg::RW-1:0]  r_i,
  output lmo_pkg::map_stat_t      stat_o,
  output logic [lmo_pkg::XW-1:0]  x_o
);
  import lmo_pkg::*;

  map_phase_e           phase_q, phase_d;
  logic [XW-1:0]        x_q;
  logic [PW-1:0]        prod_q;
  logic [XW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        prod_d;
  logic [NFULL_W-1:0]   n_full;
  logic [XW-1:0]        n_sat;

  // one shared multiplier: x*(1-x) first, then r*p
  always_comb begin
    case (phase_q)
      MP_MUL2: begin
        mul_a = r_i;
        mul_b = prod_q[FRAC_BITS+XW-1:FRAC_BITS];
      end
      default: begin
        mul_a = x_q;
        mul_b = ONE_X - x_q;
      end
    endcase
  end

  assign prod_d = PW'(mul_a) * PW'(mul_b);
  assign n_full = prod_q[PW-1:R_FRAC];
  assign n_sat  = (n_full > NFULL_W'(ONE_X)) ? ONE_X : n_full[XW-1:0];

  always_comb begin
    case (phase_q)
      MP_IDLE: phase_d = ctrl_i.start ? MP_MUL2 : MP_IDLE;
      MP_MUL2: phase_d = MP_SAT;
      default: phase_d = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MP_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((phase_q == MP_IDLE && ctrl_i.start) || phase_q == MP_MUL2) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.load_half) begin
      x_q <= HALF_X;
    end else if (phase_q == MP_SAT) begin
      x_q <= n_sat;
    end
  end

  assign stat_o.busy = (phase_q != MP_IDLE);
  assign stat_o.done = (phase_q == MP_SAT);
  assign x_o         = x_q;

endmodule

// ===== tb/logistic_map_orbit_finder_core_test.sv =====
module logistic_map_orbit_finder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lmo_pkg::*;

  localparam int unsigned MAX_VALUES  = 64;
  // longest quiet stretch of a good run is one full 65535-step transient
  localparam int unsigned STALL_LIMIT = 1_000_000;
  localparam int unsigned END_TAIL    = 500;

  // growth rates, 29 fraction bits
  localparam logic [RW-1:0] R_2P0 = 32'h4000_0000;
  localparam logic [RW-1:0] R_2P8 = 32'h5999_9999;
  localparam logic [RW-1:0] R_3P2 = 32'h6666_6666;
  localparam logic [RW-1:0] R_3P3 = 32'h6999_9999;
  localparam logic [RW-1:0] R_3P5 = 32'h7000_0000;
  localparam logic [RW-1:0] R_3P9 = 32'h7CCC_CCCC;
  localparam logic [RW-1:0] R_4P0 = 32'h8000_0000;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_BURSTY
  } sink_mode_e;

  // one orbit value as seen on the result channel
  typedef struct packed {
    logic [RW-1:0] r_echo;
    logic [XW-1:0] x_value;
    logic          is_last;
    logic          is_trunc;
  } orbit_value_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [CFG_W-1:0]  cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [RW-1:0]     r_value_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [RW-1:0]     r_echo_o;
  logic [XW-1:0]     x_value_o;
  logic              last_o;
  logic              truncated_o;

  // our copy of the register file
  logic [ITER_W-1:0] iter_cfg = ITER_RESET;
  logic [TOL_W-1:0]  tol_cfg  = TOL_RESET;

  orbit_value_t      orbit_q[$];     // orbit values still owed by the block
  orbit_value_t      orbit_want;
  orbit_value_t      orbit_got;
  int unsigned       error_cnt   = 0;
  int unsigned       idle_cycles = 0;

  // sender burst shaping and receiver stall pattern
  int unsigned       gap_max    = 0;
  int unsigned       burst_left = 0;
  sink_mode_e        sink_mode  = SINK_OPEN;
  int unsigned       ready_run  = 0;

  logistic_map_orbit_finder_core #(
    .MAX_VALUES (MAX_VALUES)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .r_value_i   (r_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .r_echo_o    (r_echo_o),
    .x_value_o   (x_value_o),
    .last_o      (last_o),
    .truncated_o (truncated_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one map step: p = x*(1-x) truncated, then r*p truncated, clipped to 1.0
  // an iterate already at 1.0 maps to zero
  function automatic logic [XW-1:0] logistic_step(input logic [RW-1:0] r,
                                                  input logic [XW-1:0] x);
    logic [63:0] prod;
    logic [63:0] nxt;
    if (x >= ONE_X) return '0;
    prod = (64'(x) * (64'(ONE_X) - 64'(x))) >> FRAC_BITS;
    nxt  = (64'(r) * prod) >> R_FRAC;
    if (nxt > 64'(ONE_X)) nxt = 64'(ONE_X);
    return nxt[XW-1:0];
  endfunction

  // run the transient from one half, then collect the orbit until an iterate
  // lands within tolerance of the settled value, the iteration bound is hit,
  // or the value cap is reached
  function automatic void predict_orbit(input logic [RW-1:0] r);
    logic [XW-1:0] x;
    logic [XW-1:0] settled;
    logic [XW-1:0] nx;
    logic [XW-1:0] x_gap;
    logic [XW-1:0] orbit[$];
    logic          trunc;
    orbit_value_t  v;
    x = HALF_X;
    trunc = 1'b0;
    for (int unsigned i = 0; i < iter_cfg; i++) x = logistic_step(r, x);
    settled = x;
    orbit.push_back(x);
    forever begin
      nx    = logistic_step(r, x);
      x_gap = (nx >= settled) ? nx - settled : settled - nx;
      if (x_gap < tol_cfg || orbit.size() > iter_cfg) break;
      if (orbit.size() >= MAX_VALUES) begin
        trunc = 1'b1;
        break;
      end
      orbit.push_back(nx);
      x = nx;
    end
    foreach (orbit[k]) begin
      v.r_echo   = r;
      v.x_value  = orbit[k];
      v.is_last  = (k == orbit.size() - 1);
      v.is_trunc = trunc && (k == orbit.size() - 1);
      orbit_q.push_back(v);
    end
  endfunction

  // check every result transfer against the oldest owed value
  always @(posedge clk_i) begin : check_results
    if (rst_ni && out_valid_o && out_ready_i) begin
      orbit_got = '{r_echo_o, x_value_o, last_o, truncated_o};
      if (orbit_q.size() == 0) begin
        error_cnt++;
        if (error_cnt <= 10)
          $display("unexpected result: r %h x %h last %b trunc %b",
                   r_echo_o, x_value_o, last_o, truncated_o);
      end else begin
        orbit_want = orbit_q.pop_front();
        if (orbit_got.r_echo !== orbit_want.r_echo || orbit_got.x_value !== orbit_want.x_value ||
            orbit_got.is_last !== orbit_want.is_last ||
            orbit_got.is_trunc !== orbit_want.is_trunc) begin
          error_cnt++;
          if (error_cnt <= 10)
            $display("mismatch (exp/got): r %h/%h x %h/%h last %b/%b trunc %b/%b",
                     orbit_want.r_echo, orbit_got.r_echo,
                     orbit_want.x_value, orbit_got.x_value,
                     orbit_want.is_last, orbit_got.is_last,
                     orbit_want.is_trunc, orbit_got.is_trunc);
        end
      end
    end
  end

  // receiver: always open, random stalls, or alternating runs and stalls
  always @(posedge clk_i) begin : drive_sink
    case (sink_mode)
      SINK_OPEN: begin
        out_ready_i <= 1'b1;
      end
      SINK_RANDOM: begin
        out_ready_i <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        if (ready_run == 0) begin
          out_ready_i <= !out_ready_i;
          ready_run   <= out_ready_i ? $urandom_range(1, 12) : $urandom_range(1, 24);
        end else begin
          ready_run <= ready_run - 1;
        end
      end
    endcase
  end

  // give up when no transfer happens for too long
  always @(posedge clk_i) begin : watchdog
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** logistic_map_orbit_finder_core: FAILED **");
        $finish;
      end
    end
  end

  // register write, only while the block is idle
  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_ITER) iter_cfg = data[ITER_W-1:0];
    else                 tol_cfg  = data[TOL_W-1:0];
    @(posedge clk_i);
  endtask

  // offer one growth rate, hold it until the transfer, then maybe pause
  task automatic send_rate(input logic [RW-1:0] r);
    in_valid_i <= 1'b1;
    r_value_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    predict_orbit(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if (gap_max > 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
    end
  endtask

  // stop offering, wait for every owed value, then a short pause
  task automatic drain();
    in_valid_i <= 1'b0;
    while (orbit_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // register values straight out of reset: converging, period two, period four, chaos
  task automatic test_reset_defaults();
    gap_max   = 5;
    sink_mode <= SINK_RANDOM;
    send_rate(R_2P8);
    send_rate(R_3P2);
    send_rate(R_3P5);
    send_rate(R_3P9);
    drain();
  endtask

  // no transient: the settled value is one half and only that value comes out
  task automatic test_zero_iterations();
    write_reg(REG_ITER, '0);
    sink_mode <= SINK_OPEN;
    gap_max   = 0;
    send_rate('0);
    send_rate(R_4P0);
    send_rate(32'h7FFF_FFFF);
    send_rate(32'hFFFF_FFFF);
    drain();
  endtask

  // rate zero, tiny, exactly 4.0, and above 4.0 where the iterate clips to 1.0
  task automatic test_rate_extremes();
    write_reg(REG_ITER, 32'd5);
    sink_mode <= SINK_BURSTY;
    gap_max   = 3;
    send_rate('0);
    send_rate(32'd1);
    send_rate(R_4P0);
    send_rate(32'h9000_0000);
    send_rate(32'hFFFF_FFFF);
    drain();
  endtask

  // zero tolerance runs into the iteration bound (63) or the value cap (64);
  // full tolerance stops right after the settled value
  task automatic test_output_cap();
    write_reg(REG_TOL, '0);
    write_reg(REG_ITER, 32'd63);
    sink_mode <= SINK_RANDOM;
    gap_max   = 0;
    send_rate(R_2P0);
    send_rate(R_3P9);
    drain();
    write_reg(REG_ITER, 32'd64);
    send_rate(R_2P0);
    send_rate(R_3P9);
    drain();
    write_reg(REG_TOL, 32'h8000_0000);
    send_rate(R_3P9);
    drain();
    // 1.0 then zero: distance is exactly the tolerance, so not a repeat
    write_reg(REG_ITER, 32'd1);
    send_rate(R_4P0);
    drain();
  endtask

  // longest transient the count register allows
  task automatic test_long_transient();
    write_reg(REG_TOL, TOL_RESET);
    write_reg(REG_ITER, 32'h0000_FFFF);
    sink_mode <= SINK_BURSTY;
    send_rate(R_3P3);
    drain();
  endtask

  // random phases: short transients mostly, rates mostly in the interesting band
  task automatic test_random_orbits();
    logic [ITER_W-1:0] iter;
    logic [TOL_W-1:0]  tol;
    logic [RW-1:0]     r;
    for (int phase = 0; phase < 12; phase++) begin
      case ($urandom_range(0, 9))
        0:       iter = '0;
        7, 8:    iter = ITER_W'($urandom_range(41, 120));
        9:       iter = ITER_W'($urandom_range(62, 66));
        default: iter = ITER_W'($urandom_range(1, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       tol = '0;
        1:       tol = $urandom_range(1, 4096);
        2:       tol = TOL_RESET;
        3:       tol = 32'h8000_0000;
        default: tol = $urandom_range(0, 32'h8000_0000);
      endcase
      // upper bits of the count write are don't-care
      write_reg(REG_ITER, {16'($urandom), iter});
      write_reg(REG_TOL, tol);
      sink_mode <= sink_mode_e'(phase % 3);
      case ($urandom_range(0, 3))
        0:       gap_max = 0;
        1:       gap_max = 3;
        2:       gap_max = 20;
        default: gap_max = 60;
      endcase
      for (int n = 0; n < 36; n++) begin
        case ($urandom_range(0, 19))
          0:       r = $urandom_range(32'h8000_0001, 32'hFFFF_FFFF);
          1, 2, 3: r = $urandom_range(0, 32'h8000_0000);
          default: r = $urandom_range(32'h5000_0000, 32'h8000_0000);
        endcase
        send_rate(r);
      end
      drain();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_zero_iterations();
    test_rate_extremes();
    test_output_cap();
    test_long_transient();
    test_random_orbits();

    drain();
    repeat (END_TAIL) @(posedge clk_i);
    if (error_cnt == 0 && orbit_q.size() == 0)
      $display("** logistic_map_orbit_finder_core: PASSED **");
    else
      $display("** logistic_map_orbit_finder_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lmo_pkg.sv
rtl/lmo_map_unit.sv
rtl/logistic_map_orbit_finder_core.sv
tb/logistic_map_orbit_finder_core_test.sv
